[rtl/stcc_pkg.sv]
// Shared types and constants for the scope trigger capture controller.
// No dependencies; used by every module of the block but the divider.
`timescale 1ns / 1ps
package stcc_pkg;

    localparam int MAX_BLOCK_SAMPLES   = 1024;
    localparam int MAX_RING_SLOTS_LOG2 = 10;
    localparam int PCT_FULL            = 100;

    // x / 100 == ((x >> 2) * PCT_RECIP) >> PCT_RECIP_SHIFT for x below 2^27
    localparam logic [25:0] PCT_RECIP       = 26'd42949673;
    localparam int          PCT_RECIP_SHIFT = 30;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 3;

    // requested mode codes (capture_mode register)
    localparam logic [1:0] REQ_OFF     = 2'd0;
    localparam logic [1:0] REQ_STREAM  = 2'd1;
    localparam logic [1:0] REQ_RISING  = 2'd2;
    localparam logic [1:0] REQ_FALLING = 2'd3;

    // running mode codes
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_STREAM = 3'd1;
    localparam logic [2:0] MODE_ARMED  = 3'd2;
    localparam logic [2:0] MODE_POST   = 3'd3;
    localparam logic [2:0] MODE_FROZEN = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLKLEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECLEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HI = 3'd7;

    typedef struct packed {
        logic accept;     // latch the input item
        logic start_a;    // register record length times percentage
        logic start_b;    // scale to pre-trigger share, start block-count division
        logic load_prod;  // register held blocks times block length
        logic exec;       // commit the item and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } ctrl_stat_t;

endpackage

[rtl/stcc_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Standalone; used by the datapath for the apply arithmetic.
`timescale 1ns / 1ps
module stcc_divider #(
    parameter int DW = 27,
    parameter int VW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [VW:0]   trial;
    logic          ge;
    logic [VW:0]   diff;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = ge ? (trial - {1'b0, dsr_reg}) : trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= diff[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

[rtl/stcc_ctrl.sv]
// Sequencing state machine: accepts items and steps the datapath.
// Depends on stcc_pkg.
`timescale 1ns / 1ps
module stcc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tuser,
    input  stcc_pkg::ctrl_stat_t stat,
    output stcc_pkg::ctrl_cmd_t  cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_AGO, ST_AWAIT, ST_BGO, ST_BWAIT, ST_PROD, ST_EXEC
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= s_tuser ? ST_AGO : ST_PROD;
                    end
                end
                ST_AGO:   state_reg <= ST_AWAIT;
                ST_AWAIT: begin
                    if (!stat.div_busy) begin
                        state_reg <= ST_BGO;
                    end
                end
                ST_BGO:   state_reg <= ST_BWAIT;
                ST_BWAIT: begin
                    if (!stat.div_busy) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_PROD:  state_reg <= ST_EXEC;
                ST_EXEC: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign cmd.accept    = s_tready && s_tvalid;
    assign cmd.start_a   = (state_reg == ST_AGO);
    assign cmd.start_b   = (state_reg == ST_BGO);
    assign cmd.load_prod = (state_reg == ST_PROD);
    assign cmd.exec      = (state_reg == ST_EXEC) && stat.out_free;
endmodule

[rtl/stcc_datapath.sv]
// Registers, apply arithmetic, tick/trigger/block logic and result register.
// Depends on stcc_pkg and stcc_divider.
`timescale 1ns / 1ps
module stcc_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  stcc_pkg::ctrl_cmd_t                    cmd,
    output stcc_pkg::ctrl_stat_t                   stat,
    input  logic [stcc_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic                                   s_tuser,
    input  logic                                   cfg_valid,
    input  logic [stcc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [31:0]                            cfg_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [stcc_pkg::M_TDATA_W-1:0]         m_tdata
);
    // configuration
    logic [1:0]         cfg_mode_reg;
    logic [15:0]        cfg_div_reg;
    logic [10:0]        cfg_spb_reg;
    logic [3:0]         cfg_log2_reg;
    logic [19:0]        cfg_rec_reg;
    logic [6:0]         cfg_pct_reg;
    logic signed [31:0] cfg_low_reg;
    logic signed [31:0] cfg_high_reg;
    // latched at apply
    logic [15:0]        act_div_reg;
    logic [10:0]        act_len_reg;
    logic [3:0]         act_log2_reg;
    logic               act_falling_reg;
    logic signed [31:0] act_low_reg;
    logic signed [31:0] act_high_reg;
    logic [19:0]        act_total_reg;
    // run state
    logic [2:0]  mode_reg;
    logic [15:0] divcnt_reg;
    logic [10:0] sib_reg;
    logic [15:0] blkcnt_reg;
    logic [15:0] wptr_reg;
    logic [10:0] held_reg;
    logic        dropping_reg;
    logic        armed_reg;
    logic [19:0] post_left_reg;
    logic [19:0] post_total_reg;
    logic [19:0] pre_needed_reg;
    logic [10:0] target_reg;
    logic [15:0] ovr_total_reg;
    logic [10:0] frozen_reg;
    // item and intermediates
    logic               item_action_reg;
    logic signed [31:0] item_sample_reg;
    logic [15:0]        item_cons_reg;
    logic [21:0]        prod_reg;
    logic [26:0]        pct_prod_reg;
    logic [50:0]        pct_scaled;
    logic [19:0]        qa_reg;
    logic                            m_tvalid_reg;
    logic [stcc_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    // divider
    logic        div_start;
    logic [26:0] div_dividend;
    logic [10:0] div_divisor;
    logic        div_busy;
    logic [26:0] div_quo;

    // pre-trigger share: divide by 4 with a shift, by 25 with a reciprocal
    assign pct_scaled   = 51'(pct_prod_reg[26:2]) * 51'(stcc_pkg::PCT_RECIP);

    assign div_start    = cmd.start_b;
    assign div_dividend = 27'(21'(cfg_rec_reg) + 21'(cfg_spb_reg) - 21'd1);
    assign div_divisor  = cfg_spb_reg;

    stcc_divider #(.DW(27), .VW(11)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // next-state values
    logic [2:0]  v_mode;
    logic [15:0] v_divcnt;
    logic [10:0] v_sib;
    logic [15:0] v_blkcnt;
    logic [15:0] v_wptr;
    logic [10:0] v_held;
    logic        v_dropping;
    logic        v_armed;
    logic [19:0] v_post_left;
    logic [19:0] v_post_total;
    logic [19:0] v_pre;
    logic [10:0] v_target;
    logic [15:0] v_ovr_total;
    logic [10:0] v_frozen;
    logic [15:0] v_act_div;
    logic [10:0] v_act_len;
    logic [3:0]  v_act_log2;
    logic        v_act_falling;
    logic signed [31:0] v_act_low;
    logic signed [31:0] v_act_high;
    logic [19:0] v_act_total;
    // result fields
    logic        o_written;
    logic [9:0]  o_slot;
    logic        o_started;
    logic [15:0] o_seq;
    logic        o_pub;
    logic [10:0] o_pubcnt;
    logic        o_ovr;
    logic        o_hit;

    always_comb begin
        logic [10:0] cap_act;
        logic [10:0] cap_cfg;
        logic [22:0] stored;
        logic        do_freeze;
        logic        ok;
        logic [19:0] post;
        logic [10:0] f;

        v_mode = mode_reg;           v_divcnt = divcnt_reg;
        v_sib = sib_reg;             v_blkcnt = blkcnt_reg;
        v_wptr = wptr_reg;           v_held = held_reg;
        v_dropping = dropping_reg;   v_armed = armed_reg;
        v_post_left = post_left_reg; v_post_total = post_total_reg;
        v_pre = pre_needed_reg;      v_target = target_reg;
        v_ovr_total = ovr_total_reg; v_frozen = frozen_reg;
        v_act_div = act_div_reg;     v_act_len = act_len_reg;
        v_act_log2 = act_log2_reg;   v_act_falling = act_falling_reg;
        v_act_low = act_low_reg;     v_act_high = act_high_reg;
        v_act_total = act_total_reg;
        o_written = 1'b0; o_slot = '0; o_started = 1'b0; o_seq = '0;
        o_pub = 1'b0; o_pubcnt = '0; o_ovr = 1'b0; o_hit = 1'b0;
        cap_act = 11'd1 << act_log2_reg;
        cap_cfg = 11'd1 << cfg_log2_reg;
        stored = '0;
        do_freeze = 1'b0;
        ok = 1'b1;
        post = '0;
        f = '0;

        if (item_action_reg) begin
            if (cfg_mode_reg == stcc_pkg::REQ_OFF) begin
                v_sib = '0; v_dropping = 1'b0; v_armed = 1'b0; v_post_left = '0;
                v_post_total = '0; v_pre = '0; v_target = '0; v_act_total = '0;
                v_mode = stcc_pkg::MODE_OFF;
            end else begin
                if (mode_reg == stcc_pkg::MODE_POST) ok = 1'b0;
                if (cfg_spb_reg == 11'd0
                    || cfg_spb_reg > 11'(stcc_pkg::MAX_BLOCK_SAMPLES)) ok = 1'b0;
                if (cfg_log2_reg > 4'(stcc_pkg::MAX_RING_SLOTS_LOG2)) ok = 1'b0;
                post = cfg_rec_reg - qa_reg;
                if (post == 20'd0) post = 20'd1;
                if (cfg_mode_reg[1]) begin
                    if (cfg_pct_reg > 7'(stcc_pkg::PCT_FULL) || cfg_rec_reg == 20'd0)
                        ok = 1'b0;
                    if (cfg_high_reg < cfg_low_reg) ok = 1'b0;
                    if (div_quo >= 27'(cap_cfg)) ok = 1'b0;   // target above ring
                end
                if (ok) begin
                    v_act_div  = (cfg_div_reg == 16'd0) ? act_div_reg : cfg_div_reg;
                    v_act_len  = cfg_spb_reg;
                    v_act_log2 = cfg_log2_reg;
                    v_sib = '0; v_dropping = 1'b0; v_armed = 1'b0; v_post_left = '0;
                    v_post_total = '0; v_pre = '0; v_target = '0; v_act_total = '0;
                    v_divcnt = 16'd1;
                    v_held = '0;
                    v_frozen = '0;
                    if (cfg_mode_reg == stcc_pkg::REQ_STREAM) begin
                        v_wptr = item_cons_reg;
                        v_mode = stcc_pkg::MODE_STREAM;
                    end else begin
                        v_wptr = '0;
                        v_act_falling = (cfg_mode_reg == stcc_pkg::REQ_FALLING);
                        v_act_low    = cfg_low_reg;
                        v_act_high   = cfg_high_reg;
                        v_act_total  = cfg_rec_reg;
                        v_post_total = post;
                        v_pre        = cfg_rec_reg - post;
                        v_target     = div_quo[10:0] + 11'd1;
                        v_mode       = stcc_pkg::MODE_ARMED;
                    end
                end
            end
        end else if (mode_reg >= stcc_pkg::MODE_STREAM && mode_reg <= stcc_pkg::MODE_POST) begin
            if (divcnt_reg > 16'd1) begin
                v_divcnt = divcnt_reg - 16'd1;
            end else begin
                v_divcnt = act_div_reg;
                if (sib_reg == 11'd0) begin
                    v_dropping = (mode_reg == stcc_pkg::MODE_STREAM)
                                 && ((wptr_reg - item_cons_reg) >= 16'(cap_act));
                    if (!v_dropping) begin
                        o_started = 1'b1;
                        o_seq     = blkcnt_reg;
                    end
                end
                o_written = !v_dropping;
                o_slot    = sib_reg[9:0];
                v_sib     = sib_reg + 11'd1;
                if (mode_reg == stcc_pkg::MODE_ARMED && act_total_reg != 20'd0) begin
                    stored = 23'(prod_reg) + 23'(v_sib);
                    if (stored > 23'(act_total_reg)) stored = 23'(act_total_reg);
                    if (stored != 23'd0 && (stored - 23'd1) >= 23'(pre_needed_reg)) begin
                        if (!armed_reg) begin
                            if (act_falling_reg ? (item_sample_reg >= act_high_reg)
                                                : (item_sample_reg <= act_low_reg))
                                v_armed = 1'b1;
                        end else if (act_falling_reg ? (item_sample_reg <= act_low_reg)
                                                     : (item_sample_reg >= act_high_reg)) begin
                            o_hit   = 1'b1;
                            v_armed = 1'b0;
                        end
                    end
                end
                if (v_sib >= act_len_reg) begin
                    if (v_dropping) begin
                        v_sib       = '0;
                        v_blkcnt    = v_blkcnt + 16'd1;
                        v_ovr_total = v_ovr_total + 16'd1;
                        o_ovr       = 1'b1;
                    end else begin
                        v_wptr   = v_wptr + 16'd1;
                        v_blkcnt = v_blkcnt + 16'd1;
                        if (v_held < cap_act) v_held = v_held + 11'd1;
                        v_sib    = '0;
                        o_pub    = 1'b1;
                        o_pubcnt = act_len_reg;
                    end
                end
                if (o_hit) begin
                    v_post_left = post_total_reg - 20'd1;
                    v_mode      = stcc_pkg::MODE_POST;
                    do_freeze   = (v_post_left == 20'd0);
                end else if (mode_reg == stcc_pkg::MODE_POST) begin
                    if (v_post_left != 20'd0) v_post_left = v_post_left - 20'd1;
                    do_freeze = (v_post_left == 20'd0);
                end
                if (do_freeze) begin
                    if (v_sib != 11'd0) begin
                        // partial block goes out before freezing
                        v_wptr   = v_wptr + 16'd1;
                        v_blkcnt = v_blkcnt + 16'd1;
                        if (v_held < cap_act) v_held = v_held + 11'd1;
                        o_pub    = 1'b1;
                        o_pubcnt = v_sib;
                        v_sib    = '0;
                    end
                    f = v_held;
                    if (target_reg != 11'd0 && f > target_reg) f = target_reg;
                    v_frozen = f;
                    v_mode   = stcc_pkg::MODE_FROZEN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode_reg <= stcc_pkg::REQ_OFF;
            cfg_div_reg  <= 16'd1;
            cfg_spb_reg  <= 11'd64;
            cfg_log2_reg <= 4'd4;
            cfg_rec_reg  <= 20'd1024;
            cfg_pct_reg  <= '0;
            cfg_low_reg  <= '0;
            cfg_high_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                stcc_pkg::CFG_MODE:    cfg_mode_reg <= cfg_data[1:0];
                stcc_pkg::CFG_DIVIDER: cfg_div_reg  <= cfg_data[15:0];
                stcc_pkg::CFG_BLKLEN:  cfg_spb_reg  <= cfg_data[10:0];
                stcc_pkg::CFG_SLOTS:   cfg_log2_reg <= cfg_data[3:0];
                stcc_pkg::CFG_RECLEN:  cfg_rec_reg  <= cfg_data[19:0];
                stcc_pkg::CFG_PCT:     cfg_pct_reg  <= cfg_data[6:0];
                stcc_pkg::CFG_TRIG_LO: cfg_low_reg  <= cfg_data;
                stcc_pkg::CFG_TRIG_HI: cfg_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_action_reg <= s_tuser;
            item_sample_reg <= s_tdata[63:32];
            item_cons_reg   <= s_tdata[79:64];
        end
        if (cmd.load_prod) prod_reg <= 22'(held_reg) * 22'(act_len_reg);
        if (cmd.start_a)   pct_prod_reg <= 27'(cfg_rec_reg) * 27'(cfg_pct_reg);
        if (cmd.start_b)   qa_reg   <= pct_scaled[49:30];
        if (cmd.exec) begin
            m_tdata_reg <= {v_frozen, v_mode, o_hit, o_ovr, o_pubcnt, o_pub,
                            (o_started ? o_seq : v_blkcnt), o_started, o_slot,
                            v_wptr, o_written};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= stcc_pkg::MODE_OFF; divcnt_reg <= '0; sib_reg <= '0;
            blkcnt_reg <= '0; wptr_reg <= '0; held_reg <= '0; dropping_reg <= 1'b0;
            armed_reg <= 1'b0; post_left_reg <= '0; post_total_reg <= '0;
            pre_needed_reg <= '0; target_reg <= '0; ovr_total_reg <= '0;
            frozen_reg <= '0;
            act_div_reg <= 16'd1; act_len_reg <= 11'd64; act_log2_reg <= 4'd4;
            act_falling_reg <= 1'b0; act_low_reg <= '0; act_high_reg <= '0;
            act_total_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                mode_reg <= v_mode; divcnt_reg <= v_divcnt; sib_reg <= v_sib;
                blkcnt_reg <= v_blkcnt; wptr_reg <= v_wptr; held_reg <= v_held;
                dropping_reg <= v_dropping; armed_reg <= v_armed;
                post_left_reg <= v_post_left; post_total_reg <= v_post_total;
                pre_needed_reg <= v_pre; target_reg <= v_target;
                ovr_total_reg <= v_ovr_total; frozen_reg <= v_frozen;
                act_div_reg <= v_act_div; act_len_reg <= v_act_len;
                act_log2_reg <= v_act_log2; act_falling_reg <= v_act_falling;
                act_low_reg <= v_act_low; act_high_reg <= v_act_high;
                act_total_reg <= v_act_total;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
endmodule

[rtl/scope_trigger_capture_controller_core.sv]
// Top level of the scope trigger capture controller.
// Depends on stcc_pkg, stcc_ctrl, stcc_datapath (and stcc_divider below it).
// ---------------------------------------------------------------------------
// Usage
//  s_ channel: one transfer per item. s_tuser is the action (0 sample tick,
//    1 apply configuration and start the selected mode).
//  m_ channel: exactly one result transfer for every input transfer, in order.
//  cfg channel: register writes by index, always ready; write only while the
//    block is idle (no result outstanding).
// Sequencing
//  A tick is latched, its held-blocks times block-length product is
//  registered and it is executed; the next item is taken only after the
//  execute step.
//  An apply forms the pre-trigger share with a registered product and a
//  reciprocal multiply, then runs one 27-step division for the blocks
//  needed; no new item is taken until its result is loaded.
// Reset
//  aresetn is synchronous, active low. Registers return to their defaults,
//  mode is off, counters and indexes are zero, no result is pending.
// Back-pressure
//  The result register holds a transfer while m_tready is low; the next item
//  is still accepted and worked on, and its execute step waits for the slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module scope_trigger_capture_controller_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] sample_time, [63:32] trigger_sample, [79:64] consumer_read_index
    input  logic [79:0] s_tdata,
    // [0] action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] sample_written, [16:1] write_index, [26:17] sample_slot,
    // [27] block_started, [43:28] block_number, [44] block_published,
    // [55:45] published_samples, [56] overrun, [57] trigger_hit,
    // [60:58] scope_mode, [71:61] frozen_blocks
    output logic [71:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    stcc_pkg::ctrl_cmd_t  cmd;
    stcc_pkg::ctrl_stat_t stat;

    // registers are plain flops, a write always completes
    assign cfg_ready = 1'b1;

    stcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    stcc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // one item in flight: after a transfer in, the input side closes
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // the last sample of a dropped block is never stored
    a_overrun_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[56] |-> !m_tdata[0])
        else $error("overrun reported on a stored sample");

    // a count only accompanies a published block
    a_pub_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[44] |-> m_tdata[55:45] == 11'd0)
        else $error("published count without a publish");

    // a trigger hit always leaves post-trigger or frozen mode
    a_hit_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[57] |-> (m_tdata[60:58] == stcc_pkg::MODE_POST
                                     || m_tdata[60:58] == stcc_pkg::MODE_FROZEN))
        else $error("trigger hit without leaving armed mode");
endmodule

[tb/sv/tb_scope_trigger_capture_controller_core.sv]
// Self-checking bench for scope_trigger_capture_controller_core: a stream
// driver, a result monitor and a cycle-free predictor of the recorder.
// Depends on stcc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_scope_trigger_capture_controller_core;
    import stcc_pkg::*;

    localparam int IDLE_LIMIT = 6000;   // cycles with no transfer at all
    localparam int ITEM_GOAL  = 1150;

    // one result, packed exactly as m_tdata (lowest field last)
    typedef struct packed {
        logic [10:0] frozen_blocks;
        logic [2:0]  scope_mode;
        logic        trigger_hit;
        logic        overrun;
        logic [10:0] published_samples;
        logic        block_published;
        logic [15:0] block_number;
        logic        block_started;
        logic [9:0]  sample_slot;
        logic [15:0] write_index;
        logic        sample_written;
    } rec_result_t;

    typedef struct packed {
        logic        action;
        logic [31:0] stamp;
        logic [31:0] level;
        logic [15:0] cons;
    } scope_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    scope_trigger_capture_controller_core i_dut (.*);

    initial forever #1 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Predictor state: register copies and the recorder's own state
    // ---------------------------------------------------------------------
    int unsigned r_mode = 0, r_div = 1, r_spb = 64, r_log2 = 4;
    int unsigned r_rec = 1024, r_pct = 0, r_lo = 0, r_hi = 0;

    int unsigned md = 0, div_cnt = 0, sib = 0, blk_cnt = 0, wp = 0, held = 0;
    int unsigned dropping = 0, armed = 0, post_left = 0, post_tot = 0;
    int unsigned pre_need = 0, tgt_blk = 0, ovr_tot = 0, frz_tot = 0;
    int unsigned act_div = 1, act_len = 64, act_log2 = 4, act_total = 0;
    bit          act_fall = 0;
    int          act_lo = 0, act_hi = 0;
    int unsigned pub_flag, pub_cnt;

    function automatic void publish_block(int unsigned n);
        wp      = (wp + 1) & 16'hFFFF;
        blk_cnt = (blk_cnt + 1) & 16'hFFFF;
        if (held < (1 << act_log2))
            held++;
        sib      = 0;
        pub_flag = 1;
        pub_cnt  = n;
    endfunction

    function automatic void freeze_capture();
        int unsigned f;
        if (sib != 0)
            publish_block(sib);
        f = held;
        if (tgt_blk != 0 && f > tgt_blk)
            f = tgt_blk;
        frz_tot = f;
        md      = MODE_FROZEN;
    endfunction

    function automatic void clear_run();
        sib = 0; dropping = 0; armed = 0; post_left = 0;
        post_tot = 0; pre_need = 0; tgt_blk = 0; act_total = 0;
    endfunction

    function automatic void start_mode(int unsigned cons);
        int unsigned tgt, post, pre, cap;
        tgt = 0; post = 0; pre = 0;
        if (r_mode == REQ_OFF) begin
            clear_run();
            md = MODE_OFF;
            return;
        end
        if (md == MODE_POST) return;
        if (r_spb == 0 || r_spb > MAX_BLOCK_SAMPLES) return;
        if (r_log2 > MAX_RING_SLOTS_LOG2) return;
        cap = 1 << r_log2;
        if (r_mode >= REQ_RISING) begin
            if (r_pct > PCT_FULL || r_rec == 0) return;
            if ($signed(r_hi) < $signed(r_lo)) return;
            pre  = (r_rec * r_pct) / PCT_FULL;
            post = r_rec - pre;
            if (post == 0) post = 1;
            pre  = r_rec - post;
            tgt  = (r_rec + r_spb - 1) / r_spb + 1;
            if (tgt > cap) return;
        end
        if (r_div != 0) act_div = r_div;   // zero keeps the previous divider
        act_len  = r_spb;
        act_log2 = r_log2;
        clear_run();
        div_cnt = 1;
        held    = 0;
        frz_tot = 0;
        if (r_mode == REQ_STREAM) begin
            wp = cons;
            md = MODE_STREAM;
        end else begin
            wp        = 0;
            act_fall  = (r_mode == REQ_FALLING);
            act_lo    = $signed(r_lo);
            act_hi    = $signed(r_hi);
            act_total = r_rec;
            post_tot  = post;
            pre_need  = pre;
            tgt_blk   = tgt;
            md        = MODE_ARMED;
        end
    endfunction

    // expected result of one accepted item; advances the predictor state
    function automatic rec_result_t record_step(scope_item_t it);
        rec_result_t r;
        int unsigned mode_was, stored, hdr;
        int          cur;
        bit          hit;
        r = '0; hit = 0; hdr = 0;
        cur = $signed(it.level);
        mode_was = md;
        pub_flag = 0; pub_cnt = 0;
        if (it.action) begin
            start_mode(it.cons);
        end else if (md >= MODE_STREAM && md <= MODE_POST) begin
            if (div_cnt > 1) begin
                div_cnt--;
            end else begin
                div_cnt = act_div;
                if (sib == 0) begin
                    dropping = (md == MODE_STREAM &&
                                ((wp - it.cons) & 16'hFFFF) >= (1 << act_log2));
                    if (!dropping) begin
                        r.block_started = 1;
                        hdr = blk_cnt;
                    end
                end
                r.sample_written = !dropping;
                r.sample_slot    = sib;
                sib++;
                if (mode_was == MODE_ARMED && act_total != 0) begin
                    stored = held * act_len + sib;
                    if (stored > act_total) stored = act_total;
                    if (stored > 0 && stored - 1 >= pre_need) begin
                        if (!act_fall) begin
                            if (!armed) begin
                                if (cur <= act_lo) armed = 1;
                            end else if (cur >= act_hi) begin
                                hit = 1; armed = 0;
                            end
                        end else begin
                            if (!armed) begin
                                if (cur >= act_hi) armed = 1;
                            end else if (cur <= act_lo) begin
                                hit = 1; armed = 0;
                            end
                        end
                    end
                end
                if (sib >= act_len) begin
                    if (dropping) begin
                        sib       = 0;
                        blk_cnt   = (blk_cnt + 1) & 16'hFFFF;
                        ovr_tot   = (ovr_tot + 1) & 16'hFFFF;
                        r.overrun = 1;
                    end else begin
                        publish_block(act_len);
                    end
                end
                if (hit) begin
                    post_left = (post_tot - 1) & 20'hFFFFF;
                    md = MODE_POST;
                    if (post_left == 0) freeze_capture();
                end else if (mode_was == MODE_POST) begin
                    if (post_left > 0) post_left--;
                    if (post_left == 0) freeze_capture();
                end
            end
        end
        r.trigger_hit       = hit;
        r.write_index       = wp;
        r.block_number      = r.block_started ? hdr : blk_cnt;
        r.block_published   = pub_flag;
        r.published_samples = pub_cnt;
        r.scope_mode        = md;
        r.frozen_blocks     = frz_tot;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: feeds s_ from the pending queue with random gaps
    // ---------------------------------------------------------------------
    scope_item_t pending_q[$];
    scope_item_t drv_item;
    int          src_gap = 0;
    bit          no_idle = 0;      // phases with back-to-back transfers
    int          n_push = 0, n_acc = 0, n_err = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                drv_item = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_item.action;
                s_tdata  <= {drv_item.cons, drv_item.level, drv_item.stamp};
                src_gap  <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off so the core backs up
    // ---------------------------------------------------------------------
    int  hold_left = 0;
    bit  pressure_done = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!pressure_done && n_acc >= 300) begin
            pressure_done <= 1'b1;
            hold_left     <= 400;
            m_tready      <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            hold_left <= $urandom_range(10, 40);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predicts on each input transfer, checks each result transfer,
    // and runs the no-progress watchdog
    // ---------------------------------------------------------------------
    rec_result_t expected_q[$];
    int          stuck_cycles = 0;

    task automatic check_field(string name, longint unsigned exp_v,
                               longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            n_err++;
        end
    endtask

    always @(posedge aclk) begin
        rec_result_t e, a;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(record_step({s_tuser, s_tdata[31:0],
                                                  s_tdata[63:32], s_tdata[79:64]}));
                n_acc++;
            end
            if (m_tvalid && m_tready) begin
                a = m_tdata;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual 0x%0h",
                             $time, m_tdata);
                    n_err++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("sample_written", e.sample_written, a.sample_written);
                    check_field("write_index", e.write_index, a.write_index);
                    check_field("sample_slot", e.sample_slot, a.sample_slot);
                    check_field("block_started", e.block_started, a.block_started);
                    check_field("block_number", e.block_number, a.block_number);
                    check_field("block_published", e.block_published,
                                a.block_published);
                    check_field("published_samples", e.published_samples,
                                a.published_samples);
                    check_field("overrun", e.overrun, a.overrun);
                    check_field("trigger_hit", e.trigger_hit, a.trigger_hit);
                    check_field("scope_mode", e.scope_mode, a.scope_mode);
                    check_field("frozen_blocks", e.frozen_blocks, a.frozen_blocks);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic push(bit act, logic [31:0] lvl, logic [15:0] cons);
        scope_item_t it;
        it.action = act;
        it.stamp  = $urandom();
        it.level  = lvl;
        it.cons   = cons;
        pending_q.push_back(it);
        n_push++;
    endtask

    // register write; caller is on a clock edge, returns once the write is
    // done, with cfg_valid low again
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:    r_mode = val & 32'h3;
            CFG_DIVIDER: r_div  = val & 32'hFFFF;
            CFG_BLKLEN:  r_spb  = val & 32'h7FF;
            CFG_SLOTS:   r_log2 = val & 32'hF;
            CFG_RECLEN:  r_rec  = val & 32'hFFFFF;
            CFG_PCT:     r_pct  = val & 32'h7F;
            CFG_TRIG_LO: r_lo   = val;
            CFG_TRIG_HI: r_hi   = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // wait until every result is back, then let the core settle
    task automatic drain();
        while (n_acc != n_push || expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_with(logic [2:0] idx, logic [31:0] val);
        drain();
        write_reg(idx, val);
        push(1'b1, $urandom(), $urandom());
    endtask

    // swing around the thresholds so edges arm and fire
    function automatic logic [31:0] near_level(int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return $urandom();
        if (r < 50) return lo - $urandom_range(0, 3);
        return hi + $urandom_range(0, 3);
    endfunction

    initial begin
        int unsigned cons, n_ticks, pick;
        int          lo, hi;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: idle core, stream with wrap and overrun ---
        push(1'b0, 32'h8000_0000, 16'hFFFF);        // tick while off
        push(1'b1, 32'h7FFF_FFFF, 16'h0000);        // off apply at reset
        drain();
        write_reg(CFG_MODE, REQ_STREAM);
        write_reg(CFG_DIVIDER, 2);
        write_reg(CFG_BLKLEN, 2);
        write_reg(CFG_SLOTS, 1);
        push(1'b1, 0, 16'hFFFF);                    // stream from 0xFFFF
        repeat (10) push(1'b0, $urandom(), 16'hFFFF);

        // --- directed: rejected applies ---
        apply_with(CFG_BLKLEN, 0);
        apply_with(CFG_BLKLEN, 2047);
        drain();
        write_reg(CFG_BLKLEN, MAX_BLOCK_SAMPLES);
        write_reg(CFG_SLOTS, 15);
        push(1'b1, 0, 0);
        drain();
        write_reg(CFG_SLOTS, MAX_RING_SLOTS_LOG2);
        write_reg(CFG_MODE, REQ_RISING);
        write_reg(CFG_RECLEN, 20'hFFFFF);           // blocks needed exceed ring
        push(1'b1, 0, 0);
        apply_with(CFG_RECLEN, 0);
        drain();
        write_reg(CFG_RECLEN, 10);
        write_reg(CFG_PCT, 127);
        push(1'b1, 0, 0);
        drain();
        write_reg(CFG_PCT, 30);
        write_reg(CFG_TRIG_LO, 5);
        write_reg(CFG_TRIG_HI, -5);                 // high below low
        push(1'b1, 0, 0);

        // --- directed: rising capture to freeze, apply during post-trigger ---
        drain();
        write_reg(CFG_DIVIDER, 1);
        write_reg(CFG_BLKLEN, 4);
        write_reg(CFG_SLOTS, 3);
        write_reg(CFG_TRIG_LO, -5);
        write_reg(CFG_TRIG_HI, 5);
        push(1'b1, 0, 0);
        for (int i = 0; i < 6; i++) push(1'b0, (i % 2) ? 10 : -10, 0);
        drain();
        write_reg(CFG_MODE, REQ_STREAM);
        push(1'b1, 0, 0);                           // refused while post-trigger
        repeat (8) push(1'b0, 0, 0);

        // --- directed: falling capture at full-scale thresholds, all pre ---
        drain();
        write_reg(CFG_MODE, REQ_FALLING);
        write_reg(CFG_PCT, 100);
        write_reg(CFG_RECLEN, 3);
        write_reg(CFG_TRIG_LO, 32'h8000_0000);
        write_reg(CFG_TRIG_HI, 32'h7FFF_FFFF);
        push(1'b1, 0, 0);
        push(1'b0, 32'h7FFF_FFFF, 0);
        push(1'b0, 32'h7FFF_FFFF, 0);
        push(1'b0, 32'h8000_0000, 0);
        push(1'b0, 32'h8000_0000, 0);
        push(1'b0, 0, 0);

        // --- random phases ---
        while (n_push < ITEM_GOAL) begin
            drain();
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            write_reg(CFG_MODE, pick < 15 ? REQ_OFF : pick < 45 ? REQ_STREAM :
                                pick < 72 ? REQ_RISING : REQ_FALLING);
            pick = $urandom_range(0, 99);
            write_reg(CFG_DIVIDER, pick < 60 ? 1 : pick < 90 ? $urandom_range(2, 3) :
                                   pick < 97 ? 0 : $urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            write_reg(CFG_BLKLEN, pick < 85 ? $urandom_range(1, 8) :
                                  pick < 92 ? MAX_BLOCK_SAMPLES : $urandom_range(0, 2047));
            pick = $urandom_range(0, 99);
            write_reg(CFG_SLOTS, pick < 90 ? $urandom_range(0, 4) :
                                 pick < 96 ? MAX_RING_SLOTS_LOG2 : $urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            write_reg(CFG_RECLEN, pick < 85 ? $urandom_range(1, 24) :
                                  pick < 92 ? 20'hFFFFF : $urandom_range(0, 20'hFFFFF));
            pick = $urandom_range(0, 99);
            write_reg(CFG_PCT, pick < 85 ? $urandom_range(0, 100) :
                               pick < 92 ? 100 : $urandom_range(0, 127));
            if ($urandom_range(0, 9) == 0) begin
                lo = $urandom(); hi = $urandom();
            end else begin
                lo = int'($urandom_range(0, 20)) - 10;
                hi = lo + int'($urandom_range(0, 10)) - ($urandom_range(0, 19) == 0);
            end
            write_reg(CFG_TRIG_LO, lo);
            write_reg(CFG_TRIG_HI, hi);
            cons = $urandom_range(0, 65535);
            push(1'b1, $urandom(), cons);
            n_ticks = $urandom_range(15, 60);
            for (int i = 0; i < n_ticks; i++) begin
                if ($urandom_range(0, 4) == 0) cons = (cons + 1) & 16'hFFFF;
                if ($urandom_range(0, 49) == 0)
                    push(1'b1, near_level(lo, hi), cons);   // re-apply mid-run
                else
                    push(1'b0, near_level(lo, hi), cons);
            end
        end

        drain();
        if (n_err == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/stcc_pkg.sv
rtl/stcc_divider.sv
rtl/stcc_ctrl.sv
rtl/stcc_datapath.sv
rtl/scope_trigger_capture_controller_core.sv
tb/sv/tb_scope_trigger_capture_controller_core.sv
